// File: hw/rtl/cas_pkg.sv
// Shared types, constants and chord/pattern tables for the chord arpeggio sequencer.
// Depends on nothing; used by the channel interfaces and the top level.
package cas_pkg;

  localparam int CAT_W   = 3;
  localparam int NUM_W   = 4;
  localparam int ROOT_W  = 7;
  localparam int NOTE_W  = 8;
  localparam int SLOT_W  = 3;
  localparam int STEP_W  = 6;
  localparam int IV_W    = 5;
  localparam int POS_W   = 4;
  localparam int LEN_W   = 5;
  localparam int REP_W   = 2;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W   = 64;

  localparam logic [LEN_W-1:0] MAX_CUSTOM_STEPS = 5'd16;
  localparam logic [2:0]       MAX_REPEATS      = 3'd4;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_PLAYBACK_MODE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ARP_ORDER      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_COUNT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CUSTOM_PATTERN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CUSTOM_LENGTH  = 3'd4;

  // arpeggio order codes
  localparam logic [2:0] ORD_ASC     = 3'd0;
  localparam logic [2:0] ORD_DESC    = 3'd1;
  localparam logic [2:0] ORD_UPDOWN  = 3'd2;
  localparam logic [2:0] ORD_DOWNUP  = 3'd3;
  localparam logic [2:0] ORD_ALT     = 3'd4;
  localparam logic [2:0] ORD_CENTER  = 3'd5;
  localparam logic [2:0] ORD_EDGES   = 3'd6;
  localparam logic [2:0] ORD_CUSTOM  = 3'd7;

  localparam logic PLAY_BLOCK = 1'b0;
  localparam logic PLAY_ARP   = 1'b1;

  typedef struct packed {
    logic [SLOT_W-1:0]         count;
    logic [4:0][IV_W-1:0]      iv;     // iv[0] is the root interval
  } shape_t;

  function automatic shape_t mk(input logic [2:0] c, input logic [4:0] a, input logic [4:0] b,
                                input logic [4:0] d, input logic [4:0] e, input logic [4:0] f);
    shape_t s;
    s.count = c;
    s.iv = {f, e, d, b, a};
    return s;
  endfunction

  function automatic logic chord_known(input logic [CAT_W-1:0] cat, input logic [NUM_W-1:0] num);
    logic ok;
    unique case (cat)
      3'd0:    ok = (num < 4'd7);
      3'd1:    ok = (num < 4'd4);
      3'd2:    ok = (num < 4'd10);
      3'd3:    ok = (num < 4'd5);
      3'd4:    ok = (num < 4'd10);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [5:0] chord_index(input logic [CAT_W-1:0] cat,
                                             input logic [NUM_W-1:0] num);
    logic [5:0] base;
    unique case (cat)
      3'd0:    base = 6'd0;
      3'd1:    base = 6'd7;
      3'd2:    base = 6'd11;
      3'd3:    base = 6'd21;
      3'd4:    base = 6'd26;
      default: base = 6'd0;
    endcase
    return base + {2'b00, num};
  endfunction

  function automatic shape_t chord_shape(input logic [5:0] idx);
    shape_t s;
    unique case (idx)
      6'd0:  s = mk(3'd3, 5'd0, 5'd4, 5'd7, 5'd0, 5'd0);
      6'd1:  s = mk(3'd3, 5'd0, 5'd3, 5'd7, 5'd0, 5'd0);
      6'd2:  s = mk(3'd3, 5'd0, 5'd3, 5'd6, 5'd0, 5'd0);
      6'd3:  s = mk(3'd3, 5'd0, 5'd4, 5'd8, 5'd0, 5'd0);
      6'd4:  s = mk(3'd3, 5'd0, 5'd2, 5'd7, 5'd0, 5'd0);
      6'd5:  s = mk(3'd3, 5'd0, 5'd5, 5'd7, 5'd0, 5'd0);
      6'd6:  s = mk(3'd2, 5'd0, 5'd7, 5'd0, 5'd0, 5'd0);
      6'd7:  s = mk(3'd4, 5'd0, 5'd4, 5'd7, 5'd9, 5'd0);
      6'd8:  s = mk(3'd4, 5'd0, 5'd3, 5'd7, 5'd9, 5'd0);
      6'd9:  s = mk(3'd5, 5'd0, 5'd4, 5'd7, 5'd9, 5'd14);
      6'd10: s = mk(3'd5, 5'd0, 5'd3, 5'd7, 5'd9, 5'd14);
      6'd11: s = mk(3'd4, 5'd0, 5'd4, 5'd7, 5'd11, 5'd0);
      6'd12: s = mk(3'd4, 5'd0, 5'd3, 5'd7, 5'd10, 5'd0);
      6'd13: s = mk(3'd4, 5'd0, 5'd4, 5'd7, 5'd10, 5'd0);
      6'd14: s = mk(3'd4, 5'd0, 5'd3, 5'd6, 5'd9, 5'd0);
      6'd15: s = mk(3'd4, 5'd0, 5'd3, 5'd6, 5'd10, 5'd0);
      6'd16: s = mk(3'd4, 5'd0, 5'd3, 5'd7, 5'd11, 5'd0);
      6'd17: s = mk(3'd4, 5'd0, 5'd4, 5'd8, 5'd11, 5'd0);
      6'd18: s = mk(3'd4, 5'd0, 5'd5, 5'd7, 5'd10, 5'd0);
      6'd19: s = mk(3'd4, 5'd0, 5'd4, 5'd6, 5'd10, 5'd0);
      6'd20: s = mk(3'd4, 5'd0, 5'd4, 5'd8, 5'd10, 5'd0);
      6'd21: s = mk(3'd5, 5'd0, 5'd4, 5'd7, 5'd11, 5'd14);
      6'd22: s = mk(3'd5, 5'd0, 5'd3, 5'd7, 5'd10, 5'd14);
      6'd23: s = mk(3'd5, 5'd0, 5'd4, 5'd7, 5'd10, 5'd14);
      6'd24: s = mk(3'd5, 5'd0, 5'd5, 5'd7, 5'd10, 5'd14);
      6'd25: s = mk(3'd5, 5'd0, 5'd4, 5'd7, 5'd10, 5'd13);
      6'd26: s = mk(3'd4, 5'd0, 5'd4, 5'd7, 5'd14, 5'd0);
      6'd27: s = mk(3'd4, 5'd0, 5'd3, 5'd7, 5'd14, 5'd0);
      6'd28: s = mk(3'd4, 5'd0, 5'd4, 5'd7, 5'd17, 5'd0);
      6'd29: s = mk(3'd4, 5'd0, 5'd4, 5'd5, 5'd7, 5'd0);
      6'd30: s = mk(3'd4, 5'd0, 5'd3, 5'd5, 5'd7, 5'd0);
      6'd31: s = mk(3'd4, 5'd0, 5'd5, 5'd7, 5'd14, 5'd0);
      6'd32: s = mk(3'd5, 5'd0, 5'd4, 5'd7, 5'd10, 5'd18);
      6'd33: s = mk(3'd5, 5'd0, 5'd3, 5'd7, 5'd10, 5'd17);
      6'd34: s = mk(3'd5, 5'd0, 5'd3, 5'd7, 5'd11, 5'd17);
      6'd35: s = mk(3'd5, 5'd0, 5'd3, 5'd6, 5'd10, 5'd13);
      default: s = mk(3'd2, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
    endcase
    return s;
  endfunction

  // Pattern length for one repeat; n is 2..5.
  function automatic logic [LEN_W-1:0] pattern_len(input logic [2:0] order,
                                                   input logic [SLOT_W-1:0] n,
                                                   input logic [LEN_W-1:0] clen);
    logic [LEN_W-1:0] nn;
    logic [LEN_W-1:0] len;
    nn = {2'b00, n};
    unique case (order)
      ORD_UPDOWN, ORD_DOWNUP: len = (n == 3'd2) ? nn : (nn + nn - 5'd2);
      ORD_CUSTOM: begin
        if (clen == 5'd0)                 len = nn;
        else if (clen > MAX_CUSTOM_STEPS) len = MAX_CUSTOM_STEPS;
        else                              len = clen;
      end
      default: len = nn;
    endcase
    return len;
  endfunction

  // Tone slot at pattern position j; may be out of range only for custom entries.
  function automatic logic [POS_W-1:0] pattern_slot(input logic [2:0] order,
                                                    input logic [SLOT_W-1:0] n,
                                                    input logic [POS_W-1:0] j,
                                                    input logic [LEN_W-1:0] clen,
                                                    input logic [CFG_W-1:0] pat);
    logic [POS_W-1:0] nn;
    logic [POS_W-1:0] s;
    nn = {1'b0, n};
    unique case (order)
      ORD_DESC:   s = nn - 4'd1 - j;
      ORD_UPDOWN: s = (j < nn) ? j : (nn + nn - 4'd2 - j);
      ORD_DOWNUP: s = (j < nn) ? (nn - 4'd1 - j) : (j - nn + 4'd1);
      ORD_ALT:    s = j[0] ? (nn - 4'd1 - (j >> 1)) : (j >> 1);
      ORD_CENTER, ORD_EDGES: begin
        if (n == 3'd3) begin
          unique case (j[1:0])
            2'd0:    s = (order == ORD_CENTER) ? 4'd1 : 4'd0;
            2'd1:    s = (order == ORD_CENTER) ? 4'd0 : 4'd2;
            default: s = (order == ORD_CENTER) ? 4'd2 : 4'd1;
          endcase
        end else if (n == 3'd4) begin
          unique case (j[1:0])
            2'd0:    s = (order == ORD_CENTER) ? 4'd1 : 4'd0;
            2'd1:    s = (order == ORD_CENTER) ? 4'd2 : 4'd3;
            2'd2:    s = (order == ORD_CENTER) ? 4'd0 : 4'd1;
            default: s = (order == ORD_CENTER) ? 4'd3 : 4'd2;
          endcase
        end else if (n == 3'd5) begin
          unique case (j[2:0])
            3'd0:    s = (order == ORD_CENTER) ? 4'd2 : 4'd0;
            3'd1:    s = (order == ORD_CENTER) ? 4'd1 : 4'd4;
            3'd2:    s = (order == ORD_CENTER) ? 4'd3 : 4'd1;
            3'd3:    s = (order == ORD_CENTER) ? 4'd0 : 4'd3;
            default: s = (order == ORD_CENTER) ? 4'd4 : 4'd2;
          endcase
        end else begin
          s = j;  // two tones: both keys tie, slot order
        end
      end
      ORD_CUSTOM: s = (clen == 5'd0) ? j : pat[{j, 2'b00} +: 4];
      default:    s = j;
    endcase
    return s;
  endfunction

endpackage

// File: hw/rtl/cas_if.sv
// Valid/ready channel interfaces for chord requests and note results.
// Depends on cas_pkg for field widths.
interface cas_req_if;
  logic                         valid;
  logic                         ready;
  logic [cas_pkg::CAT_W-1:0]    chord_category;
  logic [cas_pkg::NUM_W-1:0]    chord_number;
  logic [cas_pkg::ROOT_W-1:0]   root_note;

  modport source (output valid, output chord_category, output chord_number,
                  output root_note, input ready);
  modport sink   (input valid, input chord_category, input chord_number,
                  input root_note, output ready);
endinterface

interface cas_note_if;
  logic                         valid;
  logic                         ready;
  logic [cas_pkg::NOTE_W-1:0]   note_number;
  logic [cas_pkg::SLOT_W-1:0]   tone_slot;
  logic [cas_pkg::STEP_W-1:0]   step_number;
  logic                         last_note;

  modport source (output valid, output note_number, output tone_slot,
                  output step_number, output last_note, input ready);
  modport sink   (input valid, input note_number, input tone_slot,
                  input step_number, input last_note, output ready);
endinterface

// File: hw/rtl/chord_arpeggio_sequencer.sv
// Chord arpeggio sequencer: one request beat expands into up to 64 note beats.
// A request is accepted in idle, then walked over every pattern step (pattern length
// times repeats, 1..64 steps; block mode uses the tone count), then flushed.
// Unknown chords are accepted and dropped; no new request is taken until the flush ends.
// The step walk and the single root+interval adder set the rate; output stalls hold it.
// Sync reset loads register defaults and clears control; no memory needs clearing.
module chord_arpeggio_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  cas_req_if.sink                          req,
  cas_note_if.source                       note,
  input  logic                             cfg_we,
  input  logic [cas_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [cas_pkg::CFG_W-1:0]        cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH} state_t;

  state_t state;

  // configuration registers
  logic                          playback_mode;
  logic [2:0]                    arp_order;
  logic [2:0]                    repeat_count;
  logic [cas_pkg::CFG_W-1:0]     custom_pattern;
  logic [cas_pkg::LEN_W-1:0]     custom_length;

  // request context, loaded at accept
  logic [cas_pkg::ROOT_W-1:0]    root;
  cas_pkg::shape_t               shape;

  // step walk: pattern position, repeat, global step
  logic [cas_pkg::POS_W-1:0]     pos;
  logic [cas_pkg::REP_W-1:0]     rep;
  logic [cas_pkg::STEP_W-1:0]    step;

  // one-note holding stage: a note is released only once we know whether
  // another note follows, so last_note can be set on the final one
  logic                          hold_valid;
  logic [cas_pkg::NOTE_W-1:0]    hold_note;
  logic [cas_pkg::SLOT_W-1:0]    hold_slot;
  logic [cas_pkg::STEP_W-1:0]    hold_step;

  // output register
  logic                          out_valid;
  logic [cas_pkg::NOTE_W-1:0]    out_note;
  logic [cas_pkg::SLOT_W-1:0]    out_slot;
  logic [cas_pkg::STEP_W-1:0]    out_step;
  logic                          out_last;

  logic [2:0]                    order_eff;
  logic [cas_pkg::LEN_W-1:0]     pat_len;
  logic [cas_pkg::POS_W-1:0]     pat_slot;
  logic [cas_pkg::REP_W-1:0]     reps_m1;
  logic                          cand_valid;
  logic [cas_pkg::NOTE_W-1:0]    cand_note;
  logic                          out_free;
  logic                          stall;
  logic                          advance;
  logic                          pat_end;
  logic                          last_step;
  logic                          req_fire;
  logic                          req_known;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign req_known = cas_pkg::chord_known(req.chord_category, req.chord_number);

  // block mode walks the tones once in slot order
  assign order_eff = (playback_mode == cas_pkg::PLAY_BLOCK) ? cas_pkg::ORD_ASC : arp_order;
  assign pat_len   = cas_pkg::pattern_len(order_eff, shape.count, custom_length);
  assign pat_slot  = cas_pkg::pattern_slot(order_eff, shape.count, pos, custom_length,
                                           custom_pattern);

  always_comb begin
    if (playback_mode == cas_pkg::PLAY_BLOCK || repeat_count == 3'd0) begin
      reps_m1 = 2'd0;
    end else if (repeat_count > cas_pkg::MAX_REPEATS) begin
      reps_m1 = cas_pkg::REP_W'(cas_pkg::MAX_REPEATS - 3'd1);
    end else begin
      reps_m1 = cas_pkg::REP_W'(repeat_count - 3'd1);
    end
  end

  // out-of-range custom slots give no note but still take a step
  assign cand_valid = (pat_slot < {1'b0, shape.count});
  assign cand_note  = {1'b0, root} + {3'b000, shape.iv[pat_slot[cas_pkg::SLOT_W-1:0]]};

  assign out_free  = !out_valid || note.ready;
  assign stall     = cand_valid && hold_valid && !out_free;
  assign advance   = (state == S_RUN) && !stall;
  assign pat_end   = ({1'b0, pos} == (pat_len - 5'd1));
  assign last_step = pat_end && (rep == reps_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      hold_valid     <= 1'b0;
      out_valid      <= 1'b0;
      playback_mode  <= cas_pkg::PLAY_ARP;
      arp_order      <= cas_pkg::ORD_ASC;
      repeat_count   <= 3'd1;
      custom_pattern <= '0;
      custom_length  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cas_pkg::REG_PLAYBACK_MODE:  playback_mode  <= cfg_data[0];
          cas_pkg::REG_ARP_ORDER:      arp_order      <= cfg_data[2:0];
          cas_pkg::REG_REPEAT_COUNT:   repeat_count   <= cfg_data[2:0];
          cas_pkg::REG_CUSTOM_PATTERN: custom_pattern <= cfg_data;
          cas_pkg::REG_CUSTOM_LENGTH:  custom_length  <= cfg_data[cas_pkg::LEN_W-1:0];
          default: ;
        endcase
      end

      if (note.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire && req_known) begin
            root  <= req.root_note;
            shape <= cas_pkg::chord_shape(cas_pkg::chord_index(req.chord_category,
                                                               req.chord_number));
            pos   <= '0;
            rep   <= '0;
            step  <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (advance) begin
            if (cand_valid) begin
              if (hold_valid) begin
                out_valid <= 1'b1;
                out_note  <= hold_note;
                out_slot  <= hold_slot;
                out_step  <= hold_step;
                out_last  <= 1'b0;
              end
              hold_valid <= 1'b1;
              hold_note  <= cand_note;
              hold_slot  <= pat_slot[cas_pkg::SLOT_W-1:0];
              hold_step  <= (playback_mode == cas_pkg::PLAY_BLOCK) ? '0 : step;
            end
            step <= step + 6'd1;
            if (last_step) begin
              state <= S_FLUSH;
            end else if (pat_end) begin
              pos <= '0;
              rep <= rep + 2'd1;
            end else begin
              pos <= pos + 4'd1;
            end
          end
        end
        S_FLUSH: begin
          if (!hold_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            out_note   <= hold_note;
            out_slot   <= hold_slot;
            out_step   <= hold_step;
            out_last   <= 1'b1;
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign note.valid       = out_valid;
  assign note.note_number = out_note;
  assign note.tone_slot   = out_slot;
  assign note.step_number = out_step;
  assign note.last_note   = out_last;

`ifndef NO_ASSERTIONS
  // the holding stage is always drained before a new request is taken
  a_hold_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hold_valid)
    else $error("held note left over in idle");

  // a held note always names a real chord tone
  a_hold_slot_range: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (hold_slot < shape.count))
    else $error("held note slot out of range");

  // block-mode notes carry step zero
  a_block_step_zero: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && playback_mode == cas_pkg::PLAY_BLOCK) |-> (hold_step == '0))
    else $error("block mode note with nonzero step");

  // a known chord starts a run
  a_known_starts: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req_known) |=> (state == S_RUN))
    else $error("known chord did not start a run");

  // the step counter moves by one on every advancing step
  a_step_incr: assert property (@(posedge clk) disable iff (rst)
    (advance && !last_step) |=> (step == $past(step) + 6'd1))
    else $error("step counter skipped");
`endif

endmodule

// File: test/cas_note_checker.sv
// Note-stream checker: mirrors the register writes, expands each accepted chord
// request into the notes it should produce, and compares every note beat in order.
// Depends on cas_pkg and the cas_req_if / cas_note_if channel interfaces.
module cas_note_checker (
  input  logic                           clk,
  input  logic                           rst,
  cas_req_if                             req,
  cas_note_if                            note,
  input  logic                           cfg_we,
  input  logic [cas_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [cas_pkg::CFG_W-1:0]      cfg_data,
  output int                             mismatches,
  output int                             pending,
  output int                             notes_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import cas_pkg::*;

  typedef struct packed {
    logic [NOTE_W-1:0] pitch;
    logic [SLOT_W-1:0] slot;
    logic [STEP_W-1:0] step;
    logic              last_flag;
  } note_t;

  // interval sets, unused entries zero
  int tone_cnt [36] = '{3, 3, 3, 3, 3, 3, 2,
                        4, 4, 5, 5,
                        4, 4, 4, 4, 4, 4, 4, 4, 4, 4,
                        5, 5, 5, 5, 5,
                        4, 4, 4, 4, 4, 4, 5, 5, 5, 5};
  int iv_tab [36][5] = '{
    '{0, 4, 7, 0, 0},   '{0, 3, 7, 0, 0},   '{0, 3, 6, 0, 0},   '{0, 4, 8, 0, 0},
    '{0, 2, 7, 0, 0},   '{0, 5, 7, 0, 0},   '{0, 7, 0, 0, 0},
    '{0, 4, 7, 9, 0},   '{0, 3, 7, 9, 0},   '{0, 4, 7, 9, 14},  '{0, 3, 7, 9, 14},
    '{0, 4, 7, 11, 0},  '{0, 3, 7, 10, 0},  '{0, 4, 7, 10, 0},  '{0, 3, 6, 9, 0},
    '{0, 3, 6, 10, 0},  '{0, 3, 7, 11, 0},  '{0, 4, 8, 11, 0},  '{0, 5, 7, 10, 0},
    '{0, 4, 6, 10, 0},  '{0, 4, 8, 10, 0},
    '{0, 4, 7, 11, 14}, '{0, 3, 7, 10, 14}, '{0, 4, 7, 10, 14}, '{0, 5, 7, 10, 14},
    '{0, 4, 7, 10, 13},
    '{0, 4, 7, 14, 0},  '{0, 3, 7, 14, 0},  '{0, 4, 7, 17, 0},  '{0, 4, 5, 7, 0},
    '{0, 3, 5, 7, 0},   '{0, 5, 7, 14, 0},  '{0, 4, 7, 10, 18}, '{0, 3, 7, 10, 17},
    '{0, 3, 7, 11, 17}, '{0, 3, 6, 10, 13}};
  int cat_first [5] = '{0, 7, 11, 21, 26};
  int cat_count [5] = '{7, 4, 10, 5, 10};

  // register mirror
  logic        play_mode;
  logic [2:0]  arp_sel;
  logic [2:0]  reps_reg;
  logic [63:0] pat_reg;
  logic [4:0]  pat_len;

  note_t expected_notes[$];
  int    tone_order[$];

  task automatic report(input string msg);
    $display("%0t MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void add_tone(input int s);
    tone_order.insert(tone_order.size(), s);
  endfunction

  function automatic void add_note(input note_t nt);
    expected_notes.insert(expected_notes.size(), nt);
  endfunction

  // slot sequence of one pattern pass for an n-tone chord
  function automatic void build_order(input int n);
    int lo, hi, maxkey, key, d, cl;
    tone_order.delete();
    case (arp_sel)
      ORD_DESC:
        for (int i = n - 1; i >= 0; i--) add_tone(i);
      ORD_UPDOWN: begin
        for (int i = 0; i < n; i++) add_tone(i);
        for (int i = n - 2; i >= 1; i--) add_tone(i);
      end
      ORD_DOWNUP: begin
        for (int i = n - 1; i >= 0; i--) add_tone(i);
        for (int i = 1; i <= n - 2; i++) add_tone(i);
      end
      ORD_ALT: begin
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
          add_tone(lo);
          if (lo != hi) add_tone(hi);
          lo++;
          hi--;
        end
      end
      ORD_CENTER, ORD_EDGES: begin
        maxkey = (n - 1) / 2;
        for (int r = 0; r <= maxkey; r++) begin
          key = (arp_sel == ORD_CENTER) ? maxkey - r : r;
          for (int i = 0; i < n; i++) begin
            d = (i < n - 1 - i) ? i : n - 1 - i;
            if (d == key) add_tone(i);
          end
        end
      end
      ORD_CUSTOM: begin
        if (pat_len == 5'd0) begin
          for (int i = 0; i < n; i++) add_tone(i);
        end else begin
          cl = (pat_len > MAX_CUSTOM_STEPS) ? int'(MAX_CUSTOM_STEPS) : int'(pat_len);
          for (int i = 0; i < cl; i++) add_tone(int'(pat_reg[4*i +: 4]));
        end
      end
      default:
        for (int i = 0; i < n; i++) add_tone(i);
    endcase
  endfunction

  function automatic void expand_chord(input logic [CAT_W-1:0] cat,
                                       input logic [NUM_W-1:0] num,
                                       input logic [ROOT_W-1:0] root);
    int    idx, n, reps, step, made, s;
    note_t nt;
    if (cat > 3'd4) return;
    if (int'(num) >= cat_count[cat]) return;
    idx  = cat_first[cat] + int'(num);
    n    = tone_cnt[idx];
    made = 0;
    if (play_mode == PLAY_BLOCK) begin
      for (int i = 0; i < n; i++) begin
        nt = '{pitch: NOTE_W'(int'(root) + iv_tab[idx][i]), slot: SLOT_W'(i),
               step: '0, last_flag: 1'b0};
        add_note(nt);
        made++;
      end
    end else begin
      build_order(n);
      reps = (reps_reg == 3'd0) ? 1 : (reps_reg > MAX_REPEATS) ? int'(MAX_REPEATS)
                                                                : int'(reps_reg);
      step = 0;
      for (int r = 0; r < reps; r++) begin
        foreach (tone_order[j]) begin
          s = tone_order[j];
          if (s < n) begin
            nt = '{pitch: NOTE_W'(int'(root) + iv_tab[idx][s]), slot: SLOT_W'(s),
                   step: STEP_W'(step), last_flag: 1'b0};
            add_note(nt);
            made++;
          end
          step++;
        end
      end
    end
    if (made > 0)
      expected_notes[expected_notes.size() - 1].last_flag = 1'b1;
  endfunction

  task automatic check_note();
    note_t want;
    if (expected_notes.size() == 0) begin
      report($sformatf("unexpected note beat pitch=%0d slot=%0d step=%0d",
                       note.note_number, note.tone_slot, note.step_number));
      return;
    end
    want = expected_notes.pop_front();
    notes_checked++;
    if (note.note_number !== want.pitch)
      report($sformatf("note_number %0d, want %0d", note.note_number, want.pitch));
    if (note.tone_slot !== want.slot)
      report($sformatf("tone_slot %0d, want %0d", note.tone_slot, want.slot));
    if (note.step_number !== want.step)
      report($sformatf("step_number %0d, want %0d", note.step_number, want.step));
    if (note.last_note !== want.last_flag)
      report($sformatf("last_note %0b, want %0b", note.last_note, want.last_flag));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      play_mode     = PLAY_ARP;
      arp_sel       = ORD_ASC;
      reps_reg      = 3'd1;
      pat_reg       = '0;
      pat_len       = '0;
      mismatches    = 0;
      notes_checked = 0;
      expected_notes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PLAYBACK_MODE:  play_mode = cfg_data[0];
          REG_ARP_ORDER:      arp_sel   = cfg_data[2:0];
          REG_REPEAT_COUNT:   reps_reg  = cfg_data[2:0];
          REG_CUSTOM_PATTERN: pat_reg   = cfg_data;
          REG_CUSTOM_LENGTH:  pat_len   = cfg_data[4:0];
          default: ;
        endcase
      end
      if (note.valid && note.ready) check_note();
      if (req.valid && req.ready)
        expand_chord(req.chord_category, req.chord_number, req.root_note);
    end
    pending = expected_notes.size();
  end

endmodule

// File: test/chord_arpeggio_sequencer_tb.sv
// Testbench top for the chord arpeggio sequencer: clock, reset, register writes,
// request stimulus, note-side back-pressure and the verdict.
// Depends on cas_pkg, cas_if.sv, the sequencer RTL and cas_note_checker.
module chord_arpeggio_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cas_pkg::*;

  localparam int GAP_MAX     = 16;   // longest idle draw on either side
  localparam int HOLD_CYCLES = 400;  // long receiver hold-off, fills the block
  localparam int LINGER      = 70;   // room for an all-miss custom walk of up to 64 steps and its flush
  localparam int IDLE_LIMIT  = 3000; // cycles with no beat and no write before giving up
  localparam int PHASES      = 16;
  localparam int PHASE_ITEMS = 30;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  int mismatches, pending, notes_checked;
  int requests_sent, settings_used, idle_cycles;
  bit quiet;         // no idling on either side for the current phase
  bit hold_pending;  // ask the note side for one long hold-off

  int cat_sizes [5] = '{7, 4, 10, 5, 10};

  cas_req_if  req_ch ();
  cas_note_if note_ch ();

  chord_arpeggio_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .note      (note_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cas_note_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .note          (note_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending),
    .notes_checked (notes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: any stretch without a beat or a register write longer than the
  // limit means the block hung (or dropped notes we are waiting on).
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (note_ch.valid && note_ch.ready) || cfg_we)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles, %0d notes outstanding",
                 idle_cycles, pending);
        $display("[chord_arpeggio_sequencer] ERROR");
        $finish;
      end
    end
  end

  // Note side: random stall per beat, none in quiet phases, plus a single long
  // hold-off on request, counted here so the sender keeps pushing meanwhile.
  initial begin
    int stall;
    note_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_pending) begin
        note_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_pending = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (stall > 0) begin
          note_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      note_ch.ready <= 1'b1;
      do @(posedge clk); while (!note_ch.valid);
      @(negedge clk);
    end
  end

  // Writes all five registers back to back. Narrow registers get random junk
  // in the unused upper data bits, which the block must ignore.
  task automatic apply_settings(input logic mode, input logic [2:0] ord,
                                input logic [2:0] reps, input logic [63:0] pat,
                                input logic [4:0] len);
    logic [CFG_W-1:0]     vals [5];
    logic [REG_IDX_W-1:0] regs [5];
    logic [63:0]          junk;
    junk    = {$urandom, $urandom};
    regs[0] = REG_PLAYBACK_MODE;  vals[0] = {junk[63:1], mode};
    regs[1] = REG_ARP_ORDER;      vals[1] = {junk[63:3], ord};
    regs[2] = REG_REPEAT_COUNT;   vals[2] = {junk[63:3], reps};
    regs[3] = REG_CUSTOM_PATTERN; vals[3] = pat;
    regs[4] = REG_CUSTOM_LENGTH;  vals[4] = {junk[63:5], len};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // One request beat. Valid stays high between back-to-back beats.
  task automatic send_chord(input logic [CAT_W-1:0] cat, input logic [NUM_W-1:0] num,
                            input logic [ROOT_W-1:0] root);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.chord_category <= cat;
    req_ch.chord_number   <= num;
    req_ch.root_note      <= root;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    requests_sent++;
  endtask

  // Mostly known chords; some unknown numbers and unknown categories.
  task automatic send_random_chord();
    logic [CAT_W-1:0] cat;
    logic [NUM_W-1:0] num;
    cat = ($urandom_range(0, 7) == 0) ? CAT_W'($urandom_range(5, 7))
                                      : CAT_W'($urandom_range(0, 4));
    if (cat > 3'd4 || $urandom_range(0, 4) == 0) num = NUM_W'($urandom_range(0, 15));
    else num = NUM_W'($urandom_range(0, cat_sizes[cat] - 1));
    send_chord(cat, num, ROOT_W'($urandom_range(0, 127)));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Idle point for register writes: all notes in, plus room for a silent walk.
  task automatic settle();
    wait_drained();
    repeat (LINGER) @(negedge clk);
  endtask

  initial begin
    logic        mode;
    logic [63:0] pat;
    logic [4:0]  len;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    req_ch.valid          = 1'b0;
    req_ch.chord_category = '0;
    req_ch.chord_number   = '0;
    req_ch.root_note      = '0;
    quiet                 = 1'b0;
    hold_pending          = 1'b0;
    requests_sent         = 0;
    settings_used         = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed part ---
    // Block chords: lowest root, highest note (127 + 18), unknown chord number,
    // unknown categories, a five-tone chord.
    apply_settings(PLAY_BLOCK, ORD_ASC, 3'd1, 64'd0, 5'd0);
    send_chord(3'd0, 4'd0, 7'd0);
    send_chord(3'd4, 4'd6, 7'd127);
    send_chord(3'd0, 4'd7, 7'd60);
    send_chord(3'd5, 4'd0, 7'd60);
    send_chord(3'd7, 4'd15, 7'd127);
    send_chord(3'd3, 4'd4, 7'd127);
    // ascending, repeat count above the maximum saturates
    settle();
    apply_settings(PLAY_ARP, ORD_ASC, 3'd7, 64'd0, 5'd0);
    send_chord(3'd1, 4'd3, 7'd12);
    // descending on a two-tone chord, zero repeats acts as one
    settle();
    apply_settings(PLAY_ARP, ORD_DESC, 3'd0, 64'd0, 5'd0);
    send_chord(3'd0, 4'd6, 7'd100);
    settle();
    apply_settings(PLAY_ARP, ORD_UPDOWN, 3'd2, 64'd0, 5'd0);
    send_chord(3'd3, 4'd1, 7'd40);
    send_chord(3'd0, 4'd6, 7'd41);
    settle();
    apply_settings(PLAY_ARP, ORD_DOWNUP, 3'd1, 64'd0, 5'd0);
    send_chord(3'd2, 4'd9, 7'd50);
    settle();
    apply_settings(PLAY_ARP, ORD_ALT, 3'd3, 64'd0, 5'd0);
    send_chord(3'd4, 4'd9, 7'd30);
    send_chord(3'd0, 4'd0, 7'd31);
    settle();
    apply_settings(PLAY_ARP, ORD_CENTER, 3'd1, 64'd0, 5'd0);
    send_chord(3'd4, 4'd8, 7'd20);
    send_chord(3'd2, 4'd0, 7'd21);
    settle();
    apply_settings(PLAY_ARP, ORD_EDGES, 3'd1, 64'd0, 5'd0);
    send_chord(3'd0, 4'd2, 7'd70);
    send_chord(3'd3, 4'd2, 7'd71);
    // custom with length zero falls back to ascending
    settle();
    apply_settings(PLAY_ARP, ORD_CUSTOM, 3'd1, 64'hFEDC_BA98_7654_3210, 5'd0);
    send_chord(3'd1, 4'd2, 7'd55);
    // full custom pattern, all slots valid, four repeats: 64 notes, steps 0..63
    settle();
    apply_settings(PLAY_ARP, ORD_CUSTOM, 3'd4, 64'h4321_0432_1043_2104, 5'd16);
    send_chord(3'd3, 4'd3, 7'd127);
    // custom length above the maximum, mixed valid and out-of-range slots
    settle();
    apply_settings(PLAY_ARP, ORD_CUSTOM, 3'd2, 64'hF5F4_3210_9876_5A10, 5'd20);
    send_chord(3'd1, 4'd0, 7'd0);
    // every custom slot out of range: the request produces nothing
    settle();
    apply_settings(PLAY_ARP, ORD_CUSTOM, 3'd3, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31);
    send_chord(3'd0, 4'd0, 7'd10);

    // --- random phases ---
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      quiet = ($urandom_range(0, 3) == 0);
      mode  = ($urandom_range(0, 3) == 0) ? PLAY_BLOCK : PLAY_ARP;
      if ($urandom_range(0, 1)) begin
        pat = {$urandom, $urandom};
      end else begin
        // mostly valid slot indexes, so custom patterns actually sound
        for (int i = 0; i < 16; i++) pat[4*i +: 4] = 4'($urandom_range(0, 5));
      end
      len = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31))
                                        : 5'($urandom_range(0, 16));
      if (phase == 2) begin
        // back-pressure phase: sender never idles while the note side holds off
        quiet        = 1'b1;
        hold_pending = 1'b1;
        apply_settings(PLAY_ARP, ORD_UPDOWN, 3'd4, pat, len);
      end else begin
        apply_settings(mode, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), pat, len);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // sender pauses mid-phase until the note stream has fully drained
        if (k == PHASE_ITEMS / 2 && (phase == 1 || $urandom_range(0, 1)))
          wait_drained();
        send_random_chord();
      end
    end

    settle();
    $display("Run covered %0d chord requests under %0d register settings, %0d note beats checked.",
             requests_sent, settings_used, notes_checked);
    $display("All arpeggio orders, block mode, custom patterns and stalls exercised; %0d mismatches.",
             mismatches);
    if (mismatches == 0)
      $display("[chord_arpeggio_sequencer] OK");
    else
      $display("[chord_arpeggio_sequencer] ERROR");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/cas_pkg.sv
hw/rtl/cas_if.sv
hw/rtl/chord_arpeggio_sequencer.sv
test/cas_note_checker.sv
test/chord_arpeggio_sequencer_tb.sv
